@@ src/bms_pkg.sv @@
package bms_pkg;

  // Field widths of the request and result ports.
  localparam int ROW_W     = 9;
  localparam int COL_W     = 9;
  localparam int VAL_W     = 24;
  localparam int PT_W      = 17;
  localparam int SCALE_W   = 16;
  localparam int PROJ_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Default map geometry and coordinate format.
  localparam int DEF_MAP_COLS  = 512;
  localparam int DEF_MAP_ROWS  = 512;
  localparam int DEF_FRAC_BITS = 8;

  // Scale registers come out of reset at 1.0 in Q8.8.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_SCALE = 1'b0,
    CFG_Y_SCALE = 1'b1
  } cfg_reg_t;

  // Classification of one queued request. For a write, y0_par and x0_par
  // select the bank. For a sample, the parities of the two neighbour rows
  // and columns steer the bank outputs to the four corners.
  typedef struct packed {
    cmd_t cmd;
    logic y0_par;
    logic y1_par;
    logic x0_par;
    logic x1_par;
  } ctl_t;

  // Bits needed to index n entries, at least one.
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Bits of an index with its parity bit dropped, at least one.
  function automatic int half_bits(input int n);
    int b;
    b = idx_bits(n);
    return (b > 1) ? b - 1 : 1;
  endfunction

endpackage

@@ src/bms_front.sv @@
module bms_front
  import bms_pkg::*;
#(
  parameter int MAP_COLS  = DEF_MAP_COLS,
  parameter int MAP_ROWS  = DEF_MAP_ROWS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               in_command,
  input  logic [ROW_W-1:0]                   in_map_row,
  input  logic [COL_W-1:0]                   in_map_col,
  input  logic signed [VAL_W-1:0]            in_map_x_value,
  input  logic signed [VAL_W-1:0]            in_map_y_value,
  input  logic [PT_W-1:0]                    in_point_x,
  input  logic [PT_W-1:0]                    in_point_y,
  output logic                               push_valid,
  output ctl_t                               push_ctl,
  output logic [half_bits(MAP_ROWS)-1:0]     raddr_even,
  output logic [half_bits(MAP_ROWS)-1:0]     raddr_odd,
  output logic [half_bits(MAP_COLS)-1:0]     caddr_even,
  output logic [half_bits(MAP_COLS)-1:0]     caddr_odd,
  output logic [FRAC_BITS-1:0]               tx,
  output logic [FRAC_BITS-1:0]               ty,
  output logic signed [VAL_W-1:0]            wx,
  output logic signed [VAL_W-1:0]            wy
);

  localparam int RB  = idx_bits(MAP_ROWS);
  localparam int CB  = idx_bits(MAP_COLS);
  localparam int HRB = half_bits(MAP_ROWS);
  localparam int HCB = half_bits(MAP_COLS);

  logic            accept;
  cmd_t            cmd;
  logic            wr_ok;
  logic [PT_W-1:0] cx_raw;
  logic [PT_W-1:0] cy_raw;
  logic [CB-1:0]   px0;
  logic [CB-1:0]   px1;
  logic [RB-1:0]   py0;
  logic [RB-1:0]   py1;
  logic [RB-1:0]   wrow;
  logic [CB-1:0]   wcol;

  logic                    vld_r, vld_nxt;
  ctl_t                    ctl_r, ctl_nxt;
  logic [HRB-1:0]          re_r, re_nxt;
  logic [HRB-1:0]          ro_r, ro_nxt;
  logic [HCB-1:0]          ce_r, ce_nxt;
  logic [HCB-1:0]          co_r, co_nxt;
  logic [FRAC_BITS-1:0]    tx_r;
  logic [FRAC_BITS-1:0]    ty_r;
  logic signed [VAL_W-1:0] wx_r;
  logic signed [VAL_W-1:0] wy_r;

  assign accept = start & ~busy;
  assign cmd    = cmd_t'(in_command);

  // A write outside the map is dropped here and never reaches the queue.
  assign wr_ok = (32'(in_map_row) < 32'(MAP_ROWS)) && (32'(in_map_col) < 32'(MAP_COLS));

  // Split the point into an integer cell and clamp the cell and its
  // neighbour to the last row and column.
  assign cx_raw = in_point_x >> FRAC_BITS;
  assign cy_raw = in_point_y >> FRAC_BITS;

  always_comb begin
    px0  = (32'(cx_raw) > 32'(MAP_COLS - 1)) ? CB'(MAP_COLS - 1) : CB'(cx_raw);
    py0  = (32'(cy_raw) > 32'(MAP_ROWS - 1)) ? RB'(MAP_ROWS - 1) : RB'(cy_raw);
    px1  = (32'(px0) == 32'(MAP_COLS - 1)) ? px0 : px0 + CB'(1);
    py1  = (32'(py0) == 32'(MAP_ROWS - 1)) ? py0 : py0 + RB'(1);
    wrow = RB'(in_map_row);
    wcol = CB'(in_map_col);
  end

  // Bank addresses: each bank holds one row parity and one column parity,
  // so the even and odd neighbours are addressed separately.
  always_comb begin
    vld_nxt     = accept & ((cmd == CMD_SAMPLE) | wr_ok);
    ctl_nxt.cmd = cmd;
    unique case (cmd)
      CMD_WRITE: begin
        ctl_nxt.y0_par = wrow[0];
        ctl_nxt.y1_par = wrow[0];
        ctl_nxt.x0_par = wcol[0];
        ctl_nxt.x1_par = wcol[0];
        re_nxt         = HRB'(wrow >> 1);
        ro_nxt         = HRB'(wrow >> 1);
        ce_nxt         = HCB'(wcol >> 1);
        co_nxt         = HCB'(wcol >> 1);
      end
      CMD_SAMPLE: begin
        ctl_nxt.y0_par = py0[0];
        ctl_nxt.y1_par = py1[0];
        ctl_nxt.x0_par = px0[0];
        ctl_nxt.x1_par = px1[0];
        re_nxt         = HRB'((py0[0] ? py1 : py0) >> 1);
        ro_nxt         = HRB'((py0[0] ? py0 : py1) >> 1);
        ce_nxt         = HCB'((px0[0] ? px1 : px0) >> 1);
        co_nxt         = HCB'((px0[0] ? px0 : px1) >> 1);
      end
    endcase
  end

  // Valid flag of the front register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload of the front register.
  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r <= ctl_nxt;
      re_r  <= re_nxt;
      ro_r  <= ro_nxt;
      ce_r  <= ce_nxt;
      co_r  <= co_nxt;
      tx_r  <= in_point_x[FRAC_BITS-1:0];
      ty_r  <= in_point_y[FRAC_BITS-1:0];
      wx_r  <= in_map_x_value;
      wy_r  <= in_map_y_value;
    end
  end

  assign push_valid = vld_r;
  assign push_ctl   = ctl_r;
  assign raddr_even = re_r;
  assign raddr_odd  = ro_r;
  assign caddr_even = ce_r;
  assign caddr_odd  = co_r;
  assign tx         = tx_r;
  assign ty         = ty_r;
  assign wx         = wx_r;
  assign wy         = wy_r;

endmodule

@@ src/bms_queue.sv @@
module bms_queue
  import bms_pkg::*;
#(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  output logic [W-1:0] pop_data,
  output logic         almost_full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  // The back end never stalls, so the head leaves whenever there is one.
  assign pop       = (cnt_r != '0);
  assign pop_valid = pop;
  assign pop_data  = slot_r[rd_ptr_r];

  // The front register may still hold a request, so keep one slot spare.
  assign almost_full = (cnt_r >= CNT_W'(QUEUE_DEPTH - 1));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/bms_interp.sv @@
module bms_interp
  import bms_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                      clk,
  input  logic signed [VAL_W-1:0]   lt,
  input  logic signed [VAL_W-1:0]   rt,
  input  logic signed [VAL_W-1:0]   lb,
  input  logic signed [VAL_W-1:0]   rb,
  input  logic [FRAC_BITS-1:0]      tx,
  input  logic [FRAC_BITS-1:0]      ty,
  input  logic [SCALE_W-1:0]        scale,
  output logic signed [PROJ_W-1:0]  proj
);

  localparam int TW = VAL_W + FRAC_BITS + 2;
  localparam int VW = TW + FRAC_BITS + 1;
  localparam int PW = VW + SCALE_W + 1;
  localparam int SH = 2 * FRAC_BITS + 8;

  localparam logic signed [PW-1:0] RND  = PW'(1) <<< (SH - 1);
  localparam logic signed [PW-1:0] MAXV = PW'(33'sd2147483647);
  localparam logic signed [PW-1:0] MINV = PW'(-33'sd2147483648);

  logic signed [FRAC_BITS:0]  txs;
  logic signed [FRAC_BITS:0]  tys;
  logic signed [TW-1:0]       top_nxt, top_r;
  logic signed [TW-1:0]       bot_nxt, bot_r;
  logic [FRAC_BITS-1:0]       ty_r;
  logic signed [VW-1:0]       v_nxt, v_r;
  logic signed [PW-1:0]       p_nxt, p_r;
  logic signed [PW-1:0]       rnd;
  logic signed [PROJ_W-1:0]   proj_nxt, proj_r;

  assign txs = $signed({1'b0, tx});
  assign tys = $signed({1'b0, ty_r});

  // Horizontal pass: a*(1-t) + b*t written as a*1 + (b-a)*t.
  assign top_nxt = (TW'(lt) <<< FRAC_BITS) + (TW'(rt) - TW'(lt)) * TW'(txs);
  assign bot_nxt = (TW'(lb) <<< FRAC_BITS) + (TW'(rb) - TW'(lb)) * TW'(txs);

  // Vertical pass between the two rows.
  assign v_nxt = (VW'(top_r) <<< FRAC_BITS) + (VW'(bot_r) - VW'(top_r)) * VW'(tys);

  // Apply the axis scale.
  assign p_nxt = PW'(v_r) * PW'($signed({1'b0, scale}));

  // Round half up to Q24.8 and saturate to the signed 32-bit range.
  always_comb begin
    rnd = (p_r + RND) >>> SH;
    priority if (rnd > MAXV) begin
      proj_nxt = PROJ_W'(MAXV);
    end else if (rnd < MINV) begin
      proj_nxt = PROJ_W'(MINV);
    end else begin
      proj_nxt = rnd[PROJ_W-1:0];
    end
  end

  // Four pipeline registers: rows, column, product, result.
  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    bot_r  <= bot_nxt;
    ty_r   <= ty;
    v_r    <= v_nxt;
    p_r    <= p_nxt;
    proj_r <= proj_nxt;
  end

  assign proj = proj_r;

endmodule

@@ src/bms_back.sv @@
module bms_back
  import bms_pkg::*;
#(
  parameter int MAP_COLS  = DEF_MAP_COLS,
  parameter int MAP_ROWS  = DEF_MAP_ROWS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pop_valid,
  input  ctl_t                           pop_ctl,
  input  logic [half_bits(MAP_ROWS)-1:0] raddr_even,
  input  logic [half_bits(MAP_ROWS)-1:0] raddr_odd,
  input  logic [half_bits(MAP_COLS)-1:0] caddr_even,
  input  logic [half_bits(MAP_COLS)-1:0] caddr_odd,
  input  logic [FRAC_BITS-1:0]           tx,
  input  logic [FRAC_BITS-1:0]           ty,
  input  logic signed [VAL_W-1:0]        wx,
  input  logic signed [VAL_W-1:0]        wy,
  input  logic [SCALE_W-1:0]             x_scale,
  input  logic [SCALE_W-1:0]             y_scale,
  output logic                           out_valid,
  output logic signed [PROJ_W-1:0]       proj_x,
  output logic signed [PROJ_W-1:0]       proj_y
);

  localparam int HRB        = half_bits(MAP_ROWS);
  localparam int HCB        = half_bits(MAP_COLS);
  localparam int BANK_AW    = HRB + HCB;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int ENTRY_W    = 2 * VAL_W;
  localparam int LERP_LAT   = 4;

  logic [ENTRY_W-1:0]   rd_bus [4];
  logic                 s0_vld_r, s0_vld_nxt;
  logic                 y0_r, y1_r, x0_r, x1_r;
  logic [FRAC_BITS-1:0] tx_r;
  logic [FRAC_BITS-1:0] ty_r;
  logic [LERP_LAT-1:0]  vld_r, vld_nxt;
  logic [ENTRY_W-1:0]   lt_e, rt_e, lb_e, rb_e;

  // Four map banks, one per row and column parity. Each entry holds the
  // x map value above the y map value.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam int RP = b / 2;
    localparam int CP = b % 2;

    logic [ENTRY_W-1:0] mem [BANK_DEPTH];
    logic [ENTRY_W-1:0] q_r;
    logic [BANK_AW-1:0] addr;
    logic               we;

    assign addr = {(RP == 1) ? raddr_odd : raddr_even, (CP == 1) ? caddr_odd : caddr_even};
    assign we   = pop_valid && (pop_ctl.cmd == CMD_WRITE) &&
                  (pop_ctl.y0_par == 1'(RP)) && (pop_ctl.x0_par == 1'(CP));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[addr] <= {wx, wy};
      end
      q_r <= mem[addr];
    end

    assign rd_bus[b] = q_r;
  end

  assign s0_vld_nxt = pop_valid && (pop_ctl.cmd == CMD_SAMPLE);

  // Steering bits and fractions alongside the bank read.
  always_ff @(posedge clk) begin
    y0_r <= pop_ctl.y0_par;
    y1_r <= pop_ctl.y1_par;
    x0_r <= pop_ctl.x0_par;
    x1_r <= pop_ctl.x1_par;
    tx_r <= tx;
    ty_r <= ty;
  end

  // Sample valid through the read stage and the interpolation pipeline.
  assign vld_nxt = {vld_r[LERP_LAT-2:0], s0_vld_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      vld_r    <= '0;
    end else begin
      s0_vld_r <= s0_vld_nxt;
      vld_r    <= vld_nxt;
    end
  end

  function automatic logic [ENTRY_W-1:0] pick(input logic [1:0] sel,
                                               input logic [ENTRY_W-1:0] b0,
                                               input logic [ENTRY_W-1:0] b1,
                                               input logic [ENTRY_W-1:0] b2,
                                               input logic [ENTRY_W-1:0] b3);
    logic [ENTRY_W-1:0] r;
    unique case (sel)
      2'b00:   r = b0;
      2'b01:   r = b1;
      2'b10:   r = b2;
      default: r = b3;
    endcase
    return r;
  endfunction

  // Route the bank outputs to the four corners of the cell.
  always_comb begin
    lt_e = pick({y0_r, x0_r}, rd_bus[0], rd_bus[1], rd_bus[2], rd_bus[3]);
    rt_e = pick({y0_r, x1_r}, rd_bus[0], rd_bus[1], rd_bus[2], rd_bus[3]);
    lb_e = pick({y1_r, x0_r}, rd_bus[0], rd_bus[1], rd_bus[2], rd_bus[3]);
    rb_e = pick({y1_r, x1_r}, rd_bus[0], rd_bus[1], rd_bus[2], rd_bus[3]);
  end

  bms_interp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_interp_x (
    .clk  (clk),
    .lt   ($signed(lt_e[ENTRY_W-1:VAL_W])),
    .rt   ($signed(rt_e[ENTRY_W-1:VAL_W])),
    .lb   ($signed(lb_e[ENTRY_W-1:VAL_W])),
    .rb   ($signed(rb_e[ENTRY_W-1:VAL_W])),
    .tx   (tx_r),
    .ty   (ty_r),
    .scale(x_scale),
    .proj (proj_x)
  );

  bms_interp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_interp_y (
    .clk  (clk),
    .lt   ($signed(lt_e[VAL_W-1:0])),
    .rt   ($signed(rt_e[VAL_W-1:0])),
    .lb   ($signed(lb_e[VAL_W-1:0])),
    .rb   ($signed(rb_e[VAL_W-1:0])),
    .tx   (tx_r),
    .ty   (ty_r),
    .scale(y_scale),
    .proj (proj_y)
  );

  assign out_valid = vld_r[LERP_LAT-1];

endmodule

@@ src/bilinear_map_sampler.sv @@
// Bilinear map sampler: one request accepted per clock, sustained; the receiver cannot stall.
// A sample request's result reaches the out_ ports through the front register, queue slot,
// bank read, two interpolation stages, scale multiply, and round and saturate registers;
// writes give none. The back end drains the queue every cycle, so busy stays low.
// Synchronous reset empties the pipeline and queue and sets both scales to 1.0; map contents
// are not cleared and hold no defined value until written.
module bilinear_map_sampler
  import bms_pkg::*;
#(
  parameter int MAP_COLS  = DEF_MAP_COLS,
  parameter int MAP_ROWS  = DEF_MAP_ROWS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic [ROW_W-1:0]         in_map_row,
  input  logic [COL_W-1:0]         in_map_col,
  input  logic signed [VAL_W-1:0]  in_map_x_value,
  input  logic signed [VAL_W-1:0]  in_map_y_value,
  input  logic [PT_W-1:0]          in_point_x,
  input  logic [PT_W-1:0]          in_point_y,
  output logic                     out_valid,
  output logic signed [PROJ_W-1:0] out_proj_x,
  output logic signed [PROJ_W-1:0] out_proj_y,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SCALE_W-1:0]       cfg_wdata
);

  localparam int HRB = half_bits(MAP_ROWS);
  localparam int HCB = half_bits(MAP_COLS);
  localparam int DW  = $bits(ctl_t) + 2 * HRB + 2 * HCB + 2 * FRAC_BITS + 2 * VAL_W;

  logic [SCALE_W-1:0] x_scale_r, x_scale_nxt;
  logic [SCALE_W-1:0] y_scale_r, y_scale_nxt;

  logic                    f_valid;
  ctl_t                    f_ctl;
  logic [HRB-1:0]          f_re, f_ro;
  logic [HCB-1:0]          f_ce, f_co;
  logic [FRAC_BITS-1:0]    f_tx, f_ty;
  logic signed [VAL_W-1:0] f_wx, f_wy;

  logic                    q_valid;
  logic [DW-1:0]           q_data;
  ctl_t                    q_ctl;
  logic [HRB-1:0]          q_re, q_ro;
  logic [HCB-1:0]          q_ce, q_co;
  logic [FRAC_BITS-1:0]    q_tx, q_ty;
  logic signed [VAL_W-1:0] q_wx, q_wy;
  logic                    q_almost_full;

  // Scale register writes.
  always_comb begin
    x_scale_nxt = x_scale_r;
    y_scale_nxt = y_scale_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_X_SCALE: x_scale_nxt = cfg_wdata;
        CFG_Y_SCALE: y_scale_nxt = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r <= SCALE_RESET;
      y_scale_r <= SCALE_RESET;
    end else begin
      x_scale_r <= x_scale_nxt;
      y_scale_r <= y_scale_nxt;
    end
  end

  assign busy = q_almost_full;

  bms_front #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_map_row    (in_map_row),
    .in_map_col    (in_map_col),
    .in_map_x_value(in_map_x_value),
    .in_map_y_value(in_map_y_value),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .push_valid    (f_valid),
    .push_ctl      (f_ctl),
    .raddr_even    (f_re),
    .raddr_odd     (f_ro),
    .caddr_even    (f_ce),
    .caddr_odd     (f_co),
    .tx            (f_tx),
    .ty            (f_ty),
    .wx            (f_wx),
    .wy            (f_wy)
  );

  // Requests travel through the queue as one packed word.
  assign {q_ctl, q_re, q_ro, q_ce, q_co, q_tx, q_ty, q_wx, q_wy} = q_data;

  bms_queue #(
    .W(DW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .push_data  ({f_ctl, f_re, f_ro, f_ce, f_co, f_tx, f_ty, f_wx, f_wy}),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .almost_full(q_almost_full)
  );

  bms_back #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_valid),
    .pop_ctl   (q_ctl),
    .raddr_even(q_re),
    .raddr_odd (q_ro),
    .caddr_even(q_ce),
    .caddr_odd (q_co),
    .tx        (q_tx),
    .ty        (q_ty),
    .wx        (q_wx),
    .wy        (q_wy),
    .x_scale   (x_scale_r),
    .y_scale   (y_scale_r),
    .out_valid (out_valid),
    .proj_x    (out_proj_x),
    .proj_y    (out_proj_y)
  );

endmodule
